>>> sv/scsu_pkg.sv
// scsu_pkg: shared widths, operation codes and controller/datapath structs
// for the shadow call stack unwind unit; no dependencies
`default_nettype none

package scsu_pkg;

  // fixed field widths of the channel words
  localparam int KIND_W      = 2;
  localparam int TID_W       = 3;
  localparam int WORD_W      = 64;
  localparam int DEPTH_OUT_W = 11;

  // operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // which result the datapath captures in a cycle
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_KEEP,
    RES_OVF,
    RES_PUSH,
    RES_HIT,
    RES_MISS
  } res_e;

  typedef struct packed {
    logic load_in;
    logic rd_top;
    logic rd_next;
    res_e res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic              tid_ok;
    logic [KIND_W-1:0] kind;
    logic              depth_zero;
    logic              depth_full;
    logic              match;
    logic              idx_zero;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/scsu_in_if.sv
// scsu_in_if: request channel (valid/ready plus operation word)
// depends on scsu_pkg
`default_nettype none

interface scsu_in_if;
  import scsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;
  logic [WORD_W-1:0] stack_pointer;
  logic [WORD_W-1:0] target_address;

  modport source (output valid, kind, thread_id, stack_pointer, target_address,
                  input ready);
  modport sink   (input valid, kind, thread_id, stack_pointer, target_address,
                  output ready);
endinterface

`default_nettype wire

>>> sv/scsu_out_if.sv
// scsu_out_if: result channel (valid/ready plus result word)
// depends on scsu_pkg
`default_nettype none

interface scsu_out_if;
  import scsu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [WORD_W-1:0]      frame_address;
  logic [DEPTH_OUT_W-1:0] stack_depth;
  logic                   overflow;

  modport source (output valid, found, frame_address, stack_depth, overflow,
                  input ready);
  modport sink   (input valid, found, frame_address, stack_depth, overflow,
                  output ready);
endinterface

`default_nettype wire

>>> sv/scsu_ram.sv
// scsu_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none

module scsu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/scsu_ctrl.sv
// scsu_ctrl: sequencer for push, top read and downward search walk
// depends on scsu_pkg
`default_nettype none

module scsu_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire scsu_pkg::stat_t stat_i,
  output scsu_pkg::cmd_t       cmd_o
);
  import scsu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEPTH,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.res  = RES_NONE;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DEPTH;
        end
      end
      S_DEPTH: begin
        state_d = S_DONE;
        if (!stat_i.tid_ok) begin
          cmd_o.res = RES_ZERO;
        end else begin
          unique case (stat_i.kind) inside
            KIND_PUSH: cmd_o.res = stat_i.depth_full ? RES_OVF : RES_PUSH;
            KIND_POP, KIND_PEEK: begin
              if (stat_i.depth_zero) begin
                cmd_o.res = RES_MISS;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_SEARCH;
              end
            end
            default: cmd_o.res = RES_KEEP;
          endcase
        end
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          cmd_o.res = RES_HIT;
          state_d   = S_DONE;
        end else if (stat_i.idx_zero) begin
          cmd_o.res = RES_MISS;
          state_d   = S_DONE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/scsu_dpath.sv
// scsu_dpath: frame memories, per-thread depth memory, search index,
// result and output registers; depends on scsu_pkg and scsu_ram
`default_nettype none

module scsu_dpath #(
  parameter int STACK_DEPTH = 1024,
  parameter int THREADS     = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire scsu_pkg::cmd_t                   cmd_i,
  output scsu_pkg::stat_t                       stat_o,
  input  wire logic [scsu_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [scsu_pkg::TID_W-1:0]       thread_id_i,
  input  wire logic [scsu_pkg::WORD_W-1:0]      stack_pointer_i,
  input  wire logic [scsu_pkg::WORD_W-1:0]      target_address_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  found_o,
  output logic      [scsu_pkg::WORD_W-1:0]      frame_address_o,
  output logic      [scsu_pkg::DEPTH_OUT_W-1:0] stack_depth_o,
  output logic                                  overflow_o
);
  import scsu_pkg::*;

  localparam int ENTRIES = THREADS * STACK_DEPTH;
  localparam int DW      = $clog2(STACK_DEPTH + 1);
  localparam int IW      = $clog2(STACK_DEPTH);
  localparam int TW      = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] SD_A   = AW'(STACK_DEPTH);
  localparam logic [DW-1:0] SD_FULL = DW'(STACK_DEPTH);

  // captured request
  logic [KIND_W-1:0] kind_q;
  logic [TW-1:0]     tid_q;
  logic              tid_ok_q;
  logic [WORD_W-1:0] sp_q;
  logic [WORD_W-1:0] tgt_q;
  logic [AW-1:0]     base_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [THREADS-1:0] valid_q;

  // result and output registers
  logic              res_found_q, res_found_d;
  logic [WORD_W-1:0] res_addr_q, res_addr_d;
  logic [DW-1:0]     res_depth_q, res_depth_d;
  logic              res_ovf_q, res_ovf_d;
  logic              out_valid_q, found_q, ovf_q;
  logic [WORD_W-1:0] faddr_q;
  logic [DEPTH_OUT_W-1:0] sdepth_q;

  logic [DW-1:0]     depth_rdata, cur_depth;
  logic [WORD_W-1:0] ptr_rdata, tgt_rdata;
  logic              dwe, frd, fwe, is_pop;
  logic [AW-1:0]     f_raddr, f_waddr;

  // a thread never written reads as empty
  assign cur_depth = valid_q[tid_q] ? depth_rdata : '0;
  assign is_pop    = (kind_q == KIND_POP);

  assign idx_d   = cmd_i.rd_top ? IW'(cur_depth - DW'(1)) : idx_q - IW'(1);
  assign frd     = cmd_i.rd_top | cmd_i.rd_next;
  assign f_raddr = base_q + AW'(idx_d);
  assign f_waddr = base_q + AW'(cur_depth);
  assign fwe     = (cmd_i.res == RES_PUSH);
  assign dwe     = fwe | (is_pop & ((cmd_i.res == RES_HIT) | (cmd_i.res == RES_MISS)));

  always_comb begin
    res_found_d = 1'b0;
    res_addr_d  = '0;
    res_depth_d = cur_depth;
    res_ovf_d   = 1'b0;
    case (cmd_i.res)
      RES_ZERO: res_depth_d = '0;
      RES_OVF:  res_ovf_d   = 1'b1;
      RES_PUSH: res_depth_d = cur_depth + DW'(1);
      RES_HIT: begin
        res_found_d = 1'b1;
        res_addr_d  = tgt_rdata;
        if (is_pop) begin
          res_depth_d = DW'(idx_q);
        end
      end
      RES_MISS: begin
        if (is_pop) begin
          res_depth_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.tid_ok     = tid_ok_q;
  assign stat_o.kind       = kind_q;
  assign stat_o.depth_zero = (cur_depth == '0);
  assign stat_o.depth_full = (cur_depth == SD_FULL);
  assign stat_o.match      = (ptr_rdata == sp_q);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (dwe) begin
        valid_q[tid_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q   <= kind_i;
      tid_q    <= TW'(thread_id_i);
      tid_ok_q <= (32'(thread_id_i) < THREADS);
      sp_q     <= stack_pointer_i;
      tgt_q    <= target_address_i;
      base_q   <= AW'(AW'(thread_id_i) * SD_A);
    end
    if (frd) begin
      idx_q <= idx_d;
    end
    if (cmd_i.res != RES_NONE) begin
      res_found_q <= res_found_d;
      res_addr_q  <= res_addr_d;
      res_depth_q <= res_depth_d;
      res_ovf_q   <= res_ovf_d;
    end
    if (cmd_i.out_load) begin
      found_q  <= res_found_q;
      faddr_q  <= res_addr_q;
      sdepth_q <= DEPTH_OUT_W'(res_depth_q);
      ovf_q    <= res_ovf_q;
    end
  end

  scsu_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (f_waddr),
    .wdata_i (sp_q),
    .re_i    (frd),
    .raddr_i (f_raddr),
    .rdata_o (ptr_rdata)
  );

  scsu_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (f_waddr),
    .wdata_i (tgt_q),
    .re_i    (frd),
    .raddr_i (f_raddr),
    .rdata_o (tgt_rdata)
  );

  scsu_ram #(.WIDTH(DW), .DEPTH(THREADS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (tid_q),
    .wdata_i (res_depth_d),
    .re_i    (cmd_i.load_in),
    .raddr_i (TW'(thread_id_i)),
    .rdata_o (depth_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign frame_address_o = faddr_q;
  assign stack_depth_o   = sdepth_q;
  assign overflow_o      = ovf_q;

endmodule

`default_nettype wire

>>> sv/shadow_call_stack_unwind_unit.sv
// shadow_call_stack_unwind_unit: top level, per-thread shadow call stack
// depends on scsu_pkg, scsu_in_if, scsu_out_if, scsu_ctrl, scsu_dpath
//
// usage
//   in_i carries one operation word: push a (stack pointer, target) pair,
//   pop down to the newest frame whose stack pointer matches, or peek at it.
//   out_o returns one result word per operation: found flag, matched target,
//   thread depth after the operation (low 11 bits) and the push overflow flag
// sequence, for each accepted word
//   push, unused kind, bad thread id, empty stack: decided after the depth read
//   pop/peek: reads the top frame, then walks down one frame at a time until
//   a match or the bottom entry; a miss walks all the way to the bottom entry
//   the walk reads one frame per cycle through the single read port of the
//   frame memories, so the search depth sets how long a pop or peek takes
// one word is in flight at a time; the finished result sits in an output
// register so a new word is taken while the previous result waits
// when the receiver stalls, the next result holds inside the block and no
// further word is accepted until the output register frees up
// reset clears the per-thread valid bits, so every stack reads empty right
// away; no clearing pass, the frame memories hold garbage until pushed
`default_nettype none

module shadow_call_stack_unwind_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int THREADS     = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  scsu_in_if.sink     in_i,
  scsu_out_if.source  out_o
);
  import scsu_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  logic in_ready;

  scsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // the datapath owns the frame memories and the output register
  scsu_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .THREADS     (THREADS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (in_i.kind),
    .thread_id_i      (in_i.thread_id),
    .stack_pointer_i  (in_i.stack_pointer),
    .target_address_i (in_i.target_address),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .found_o          (out_o.found),
    .frame_address_o  (out_o.frame_address),
    .stack_depth_o    (out_o.stack_depth),
    .overflow_o       (out_o.overflow)
  );

  assign in_i.ready = in_ready;

  // result register never loaded while a stalled word still sits in it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result loaded over a stalled word");

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("word accepted while another is in flight");

  // the downward walk never steps below entry 0
  a_walk_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_next |-> !stat.idx_zero)
    else $error("search walked below the bottom frame");

  // a push is only stored when the stack has room and the thread id is valid
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.res == RES_PUSH) |-> (!stat.depth_full && stat.tid_ok))
    else $error("push stored on a full stack or bad thread");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench: directed table plus random push/pop/peek words for the shadow call stack,
// checked word by word against typed row expectations or a behavioral per-thread stack
// depends on scsu_pkg, scsu_in_if, scsu_out_if and shadow_call_stack_unwind_unit
`default_nettype none

module testbench;
  import scsu_pkg::*;

  localparam int STACK_ENTRIES = 1024;
  localparam int THREAD_COUNT  = 8;

  // kind 3 has no operation behind it, the block only reports the depth
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int MAX_WAIT     = 17;
  localparam int RANDOM_WORDS = 783;
  localparam int HOLD_OFF_LEN = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;
  // ~1850 words plus a handful of full-depth walks; the limit is generous
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] ALT_A    = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic [WORD_W-1:0] TGT_A    = 64'h0123_4567_89ab_cdef;
  localparam logic [WORD_W-1:0] FILL_SP  = 64'h0000_7fff_f000_0000;
  localparam logic [WORD_W-1:0] FILL_TGT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
    logic [WORD_W-1:0] stack_pointer;
    logic [WORD_W-1:0] target_address;
  } stack_op_t;

  typedef struct packed {
    logic                   found;
    logic [WORD_W-1:0]      frame_address;
    logic [DEPTH_OUT_W-1:0] stack_depth;
    logic                   overflow;
  } stack_result_t;

  // one row of the directed table; reps > 1 repeats the word with stack
  // pointer and target stepping by one, typed rows carry a fixed expectation
  typedef struct {
    stack_op_t     op;
    int            reps;
    bit            typed;
    stack_result_t want;
  } stim_row_t;

  localparam stack_result_t EMPTY_RESULT = '0;

  logic clk_i;
  logic rst_ni;

  scsu_in_if  in_bus ();
  scsu_out_if out_bus ();

  shadow_call_stack_unwind_unit #(
    .STACK_DEPTH (STACK_ENTRIES),
    .THREADS     (THREAD_COUNT)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // behavioral copy of the per-thread stacks
  logic [WORD_W-1:0] shadow_sp     [THREAD_COUNT][STACK_ENTRIES];
  logic [WORD_W-1:0] shadow_target [THREAD_COUNT][STACK_ENTRIES];
  int                shadow_depth  [THREAD_COUNT];

  stack_result_t pending_results [$];
  stim_row_t     directed_rows [$];

  int mismatch_count;
  int cycle_count;
  int hold_off_cycles;
  bit src_burst;
  bit sink_burst;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // applies one word to the shadow stacks and returns the result word it
  // should produce; thread ids never go out of range with 8 threads
  function automatic stack_result_t apply_stack_op(stack_op_t op);
    stack_result_t res;
    int            depth;
    int            idx;
    res   = '0;
    depth = shadow_depth[op.thread_id];
    case (op.kind)
      KIND_PUSH: begin
        if (depth >= STACK_ENTRIES) begin
          // full stack: word dropped, depth kept
          res.overflow = 1'b1;
        end else begin
          shadow_sp[op.thread_id][depth]     = op.stack_pointer;
          shadow_target[op.thread_id][depth] = op.target_address;
          depth++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        // newest matching frame wins, the bottom entry included
        idx = depth - 1;
        while (idx >= 0 && shadow_sp[op.thread_id][idx] != op.stack_pointer) idx--;
        if (idx >= 0) begin
          res.found         = 1'b1;
          res.frame_address = shadow_target[op.thread_id][idx];
          if (op.kind == KIND_POP) depth = idx;
        end else if (op.kind == KIND_POP) begin
          // unmatched return unwinds the whole stack
          depth = 0;
        end
      end
      default: ;
    endcase
    shadow_depth[op.thread_id] = depth;
    res.stack_depth = DEPTH_OUT_W'(depth);
    return res;
  endfunction

  function automatic stack_result_t result_word(logic found, logic [WORD_W-1:0] addr,
                                                int depth, logic ovf);
    stack_result_t res;
    res.found         = found;
    res.frame_address = addr;
    res.stack_depth   = DEPTH_OUT_W'(depth);
    res.overflow      = ovf;
    return res;
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [TID_W-1:0] tid,
                                  logic [WORD_W-1:0] sp, logic [WORD_W-1:0] tgt,
                                  int reps, bit typed, stack_result_t want);
    stim_row_t row;
    row.op    = '{kind, tid, sp, tgt};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_wait(bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // offers one word after a random gap and holds it until the block takes it;
  // the expectation is queued at the accepting edge
  task automatic send_op(input stack_op_t op, input bit typed, input stack_result_t want);
    int            gap;
    stack_result_t predicted;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = pick_wait(src_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid          = 1'b1;
    in_bus.kind           = op.kind;
    in_bus.thread_id      = op.thread_id;
    in_bus.stack_pointer  = op.stack_pointer;
    in_bus.target_address = op.target_address;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    predicted = apply_stack_op(op);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // result checker: every accepted result word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    stack_result_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, frame_address",
                        out_bus.frame_address, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.found !== want.found)
          report_mismatch("found", WORD_W'(out_bus.found), WORD_W'(want.found));
        if (out_bus.frame_address !== want.frame_address)
          report_mismatch("frame_address", out_bus.frame_address, want.frame_address);
        if (out_bus.stack_depth !== want.stack_depth)
          report_mismatch("stack_depth", WORD_W'(out_bus.stack_depth),
                          WORD_W'(want.stack_depth));
        if (out_bus.overflow !== want.overflow)
          report_mismatch("overflow", WORD_W'(out_bus.overflow), WORD_W'(want.overflow));
      end
    end
  end

  // receiver: random stall before each result word, bursts of no stall, and
  // one long hold-off on request so the block backs up into its input
  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    sink_burst    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = pick_wait(sink_burst);
      end
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("shadow_call_stack_unwind_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    stack_op_t op;
    stim_row_t row;
    int        d;
    int        pick;
    int        idx;

    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.kind           = KIND_PUSH;
    in_bus.thread_id      = '0;
    in_bus.stack_pointer  = '0;
    in_bus.target_address = '0;
    mismatch_count        = 0;
    hold_off_cycles       = 0;
    src_burst             = 1'b0;
    foreach (shadow_depth[t]) shadow_depth[t] = 0;

    // after reset every stack reads empty
    add_row(KIND_PEEK,   0, '0,       ALL_ONES, 1, 1'b1, result_word(0, '0, 0, 0));
    add_row(KIND_POP,    0, ALL_ONES, '0,       1, 1'b1, result_word(0, '0, 0, 0));
    add_row(KIND_UNUSED, 0, ALL_ONES, ALL_ONES, 1, 1'b1, result_word(0, '0, 0, 0));
    // extremes of pointer and target, a duplicate pointer on top
    add_row(KIND_PUSH,   0, '0,       ALL_ONES, 1, 1'b1, result_word(0, '0, 1, 0));
    add_row(KIND_PUSH,   0, ALL_ONES, '0,       1, 1'b1, result_word(0, '0, 2, 0));
    add_row(KIND_PUSH,   0, ALT_5,    ALT_A,    1, 1'b1, result_word(0, '0, 3, 0));
    add_row(KIND_PUSH,   0, '0,       TGT_A,    1, 1'b1, result_word(0, '0, 4, 0));
    // peek sees the newest of the two zero pointers
    add_row(KIND_PEEK,   0, '0,       '0,       1, 1'b1, result_word(1, TGT_A, 4, 0));
    add_row(KIND_UNUSED, 0, '0,       ALT_5,    1, 1'b1, result_word(0, '0, 4, 0));
    // peek miss keeps the depth
    add_row(KIND_PEEK,   0, ALT_A,    '0,       1, 1'b1, result_word(0, '0, 4, 0));
    // pop unwinds the match and the two frames above it
    add_row(KIND_POP,    0, ALL_ONES, '0,       1, 1'b1, result_word(1, '0, 1, 0));
    // peek matching the bottom entry
    add_row(KIND_PEEK,   0, '0,       '0,       1, 1'b1, result_word(1, ALL_ONES, 1, 0));
    add_row(KIND_PUSH,   1, ALT_A,    ALT_5,    1, 1'b0, EMPTY_RESULT);
    add_row(KIND_PUSH,   1, 64'd1,    64'd2,    1, 1'b0, EMPTY_RESULT);
    // pop miss empties the stack
    add_row(KIND_POP,    1, ALT_5,    '0,       1, 1'b1, result_word(0, '0, 0, 0));
    add_row(KIND_POP,    0, '0,       '0,       1, 1'b1, result_word(1, ALL_ONES, 0, 0));
    add_row(KIND_PUSH,   5, FILL_SP,  FILL_TGT, 20, 1'b0, EMPTY_RESULT);
    add_row(KIND_POP,    5, ALL_ONES, '0,       1, 1'b1, result_word(0, '0, 0, 0));
    // fill one thread to the top, then overflow and full-depth searches
    add_row(KIND_PUSH,   7, FILL_SP,  FILL_TGT, STACK_ENTRIES, 1'b0, EMPTY_RESULT);
    add_row(KIND_PUSH,   7, '0,       '0,       1, 1'b1,
            result_word(0, '0, STACK_ENTRIES, 1));
    add_row(KIND_PEEK,   7, ALL_ONES, '0,       1, 1'b1,
            result_word(0, '0, STACK_ENTRIES, 0));
    add_row(KIND_PEEK,   7, FILL_SP,  '0,       1, 1'b1,
            result_word(1, FILL_TGT, STACK_ENTRIES, 0));
    add_row(KIND_POP,    7, FILL_SP + STACK_ENTRIES - 1, '0, 1, 1'b1,
            result_word(1, FILL_TGT + STACK_ENTRIES - 1, STACK_ENTRIES - 1, 0));
    add_row(KIND_POP,    7, FILL_SP,  '0,       1, 1'b1, result_word(1, FILL_TGT, 0, 0));
    add_row(KIND_UNUSED, 7, ALT_A,    ALT_A,    1, 1'b1, result_word(0, '0, 0, 0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      op  = row.op;
      for (int n = 0; n < row.reps; n++) begin
        send_op(op, row.typed, row.want);
        op.stack_pointer++;
        op.target_address++;
      end
    end

    // random part: mostly call/return traffic whose returns hit frames that
    // are really on the stack, with some misses, duplicates and raw noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) hold_off_cycles = HOLD_OFF_LEN;
      op.thread_id      = TID_W'($urandom_range(0, THREAD_COUNT - 1));
      op.stack_pointer  = {$urandom, $urandom};
      op.target_address = {$urandom, $urandom};
      d    = shadow_depth[op.thread_id];
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op.kind = KIND_UNUSED;
      end else if (pick < 10) begin
        op.kind = KIND_W'($urandom_range(0, 3));
      end else if (pick < (d < 4 ? 65 : (d > 48 ? 25 : 50))) begin
        op.kind = KIND_PUSH;
        // a few small pointers so that stacks hold duplicates
        if ($urandom_range(0, 3) == 0) op.stack_pointer = WORD_W'($urandom_range(0, 3));
      end else begin
        op.kind = ($urandom_range(0, 4) < 3) ? KIND_POP : KIND_PEEK;
        if (d > 0 && $urandom_range(0, 3) != 0) begin
          // mostly the top frame, otherwise a deeper one
          idx = ($urandom_range(0, 1) == 0) ? d - 1 : int'($urandom_range(0, d - 1));
          op.stack_pointer = shadow_sp[op.thread_id][idx];
        end else if ($urandom_range(0, 1) == 0) begin
          op.stack_pointer = WORD_W'($urandom_range(0, 3));
        end
      end
      send_op(op, 1'b0, EMPTY_RESULT);
    end

    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("shadow_call_stack_unwind_unit verification clean");
    end else begin
      $display("shadow_call_stack_unwind_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/scsu_pkg.sv
sv/scsu_in_if.sv
sv/scsu_out_if.sv
sv/scsu_ram.sv
sv/scsu_ctrl.sv
sv/scsu_dpath.sv
sv/shadow_call_stack_unwind_unit.sv
sim/testbench.sv
